// File: hdl/bre_pkg.sv
package bre_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int SLICES_DEF     = 36;
  localparam int ADDR_MAX_W     = 6;

  localparam logic [14:0]        HIT_RADIUS_RST = 15'd1638;
  localparam logic signed [15:0] POINT0_COORD   = -16'sd8192;
  localparam logic [16:0]        T_ONE          = 17'd65536;

  localparam logic [2:0] MODE_CLEAR   = 3'd0;
  localparam logic [2:0] MODE_PRESS   = 3'd1;
  localparam logic [2:0] MODE_DRAG    = 3'd2;
  localparam logic [2:0] MODE_RELEASE = 3'd3;
  localparam logic [2:0] MODE_EVAL    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FEW   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NOSEL = 2'd3;

  localparam longint unsigned Q30_ONE      = 64'd1073741824;
  localparam longint unsigned PI_OVER4_Q30 = 64'd843314857;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PRESS_RD,
    S_PRESS_SQ,
    S_PRESS_CMP,
    S_EVAL_RD0,
    S_EVAL_LD0,
    S_EVAL_RD,
    S_EVAL_MUL,
    S_EVAL_WR,
    S_REV_MUL,
    S_REV_SAT,
    S_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    MUL_HIT,
    MUL_BLEND,
    MUL_REV
  } mul_op_t;

  typedef struct packed {
    logic                  latch_in;
    logic                  rd_en;
    logic [ADDR_MAX_W-1:0] rd_addr;
    logic                  src_point;
    logic                  pt_we;
    logic [ADDR_MAX_W-1:0] pt_addr;
    logic                  wk_we;
    logic [ADDR_MAX_W-1:0] wk_addr;
    mul_op_t               mul_op;
    logic                  ld_prev;
    logic                  ld_curve;
    logic                  clr_result;
    logic                  ld_surface;
    logic                  ld_out;
  } bre_cmd_t;

  typedef struct packed {
    logic hit;
  } bre_sts_t;

  // {sin, cos} in Q2.14 of slice Idx out of Slices
  function automatic logic [31:0] slice_trig(int unsigned Idx, int unsigned Slices);
    longint unsigned m, oct, r, th, x2, a, s, c, tmp, sa, ca;
    logic [15:0] sn, cs;
    m   = longint'(Idx % Slices);
    oct = (64'd8 * m) / Slices;
    r   = 64'd8 * m - oct * Slices;
    if (oct[0]) th = ((Slices - r) * PI_OVER4_Q30) / Slices;
    else        th = (r * PI_OVER4_Q30) / Slices;
    x2 = (th * th) >> 30;
    a  = Q30_ONE - x2 / 72;
    a  = Q30_ONE - ((x2 * a) >> 30) / 42;
    a  = Q30_ONE - ((x2 * a) >> 30) / 20;
    a  = Q30_ONE - ((x2 * a) >> 30) / 6;
    s  = (th * a) >> 30;
    a  = Q30_ONE - x2 / 90;
    a  = Q30_ONE - ((x2 * a) >> 30) / 56;
    a  = Q30_ONE - ((x2 * a) >> 30) / 30;
    a  = Q30_ONE - ((x2 * a) >> 30) / 12;
    c  = Q30_ONE - ((x2 * a) >> 30) / 2;
    if (oct[0]) begin
      tmp = s;
      s   = c;
      c   = tmp;
    end
    sa = (s + 64'd32768) >> 16;
    ca = (c + 64'd32768) >> 16;
    case ((oct >> 1) & 64'd3)
      64'd0: begin
        sn = 16'(sa);
        cs = 16'(ca);
      end
      64'd1: begin
        sn = 16'(ca);
        cs = 16'(-sa);
      end
      64'd2: begin
        sn = 16'(-sa);
        cs = 16'(-ca);
      end
      default: begin
        sn = 16'(-ca);
        cs = 16'(sa);
      end
    endcase
    return {sn, cs};
  endfunction

endpackage

// File: hdl/bre_ctrl.sv
module bre_ctrl #(
  parameter int MAX_POINTS = bre_pkg::MAX_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_mode,
  input  logic              in_left_held,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [3:0]        out_selected_index,
  output logic              out_selected_valid,
  output logic [4:0]        out_point_total,
  output bre_pkg::bre_cmd_t cmd,
  input  bre_pkg::bre_sts_t sts
);
  import bre_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  ctl_state_t      state_r, state_nxt;
  logic [2:0]      mode_r, mode_nxt;
  logic            held_r, held_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [IW-1:0]   sel_idx_r, sel_idx_nxt;
  logic            sel_act_r, sel_act_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [IW-1:0]   lim_r, lim_nxt;
  logic            first_r, first_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [3:0]      out_sel_idx_r, out_sel_idx_nxt;
  logic            out_sel_valid_r, out_sel_valid_nxt;
  logic [4:0]      out_total_r, out_total_nxt;

  logic          take;
  logic          press_last;
  logic          list_full;
  logic          round_end;
  logic [IW-1:0] lim_m1;

  assign take       = !out_valid_r || !out_stall;
  assign press_last = (idx_r == IW'(cnt_r - 1'b1));
  assign list_full  = (cnt_r == CW'(MAX_POINTS));
  assign lim_m1     = IW'(lim_r - 1'b1);
  assign round_end  = (idx_r == lim_m1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        case (mode_r)
          MODE_PRESS: state_nxt = (cnt_r == '0) ? S_DONE : S_PRESS_RD;
          MODE_EVAL:  state_nxt = (cnt_r < CW'(2)) ? S_DONE : S_EVAL_RD0;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_PRESS_RD:  state_nxt = S_PRESS_SQ;
      S_PRESS_SQ:  state_nxt = S_PRESS_CMP;
      S_PRESS_CMP: state_nxt = (sts.hit || press_last) ? S_DONE : S_PRESS_RD;
      S_EVAL_RD0:  state_nxt = S_EVAL_LD0;
      S_EVAL_LD0:  state_nxt = S_EVAL_RD;
      S_EVAL_RD:   state_nxt = S_EVAL_MUL;
      S_EVAL_MUL:  state_nxt = S_EVAL_WR;
      S_EVAL_WR: begin
        if (!round_end)            state_nxt = S_EVAL_RD;
        else if (lim_r == IW'(1))  state_nxt = S_REV_MUL;
        else                       state_nxt = S_EVAL_RD0;
      end
      S_REV_MUL:   state_nxt = S_REV_SAT;
      S_REV_SAT:   state_nxt = S_DONE;
      S_DONE:      if (take) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.mul_op = MUL_HIT;
    case (state_r)
      S_IDLE: cmd.latch_in = in_valid;
      S_DECODE: begin
        cmd.clr_result = 1'b1;
        if (mode_r == MODE_PRESS && cnt_r == '0) begin
          cmd.pt_we   = 1'b1;
          cmd.pt_addr = '0;
        end
        if (mode_r == MODE_DRAG && sel_act_r && held_r) begin
          cmd.pt_we   = 1'b1;
          cmd.pt_addr = ADDR_MAX_W'(sel_idx_r);
        end
      end
      S_PRESS_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr   = ADDR_MAX_W'(idx_r);
        cmd.src_point = 1'b1;
      end
      S_PRESS_SQ: cmd.mul_op = MUL_HIT;
      S_PRESS_CMP: begin
        if (!sts.hit && press_last && !list_full) begin
          cmd.pt_we   = 1'b1;
          cmd.pt_addr = ADDR_MAX_W'(cnt_r);
        end
      end
      S_EVAL_RD0: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr   = '0;
        cmd.src_point = first_r;
      end
      S_EVAL_LD0: cmd.ld_prev = 1'b1;
      S_EVAL_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr   = ADDR_MAX_W'(idx_r + 1'b1);
        cmd.src_point = first_r;
      end
      S_EVAL_MUL: cmd.mul_op = MUL_BLEND;
      S_EVAL_WR: begin
        cmd.wk_we    = 1'b1;
        cmd.wk_addr  = ADDR_MAX_W'(idx_r);
        cmd.ld_prev  = 1'b1;
        cmd.ld_curve = round_end && (lim_r == IW'(1));
      end
      S_REV_MUL: cmd.mul_op = MUL_REV;
      S_REV_SAT: cmd.ld_surface = 1'b1;
      S_DONE:    cmd.ld_out = take;
      default: ;
    endcase
  end

  always_comb begin
    mode_nxt          = mode_r;
    held_nxt          = held_r;
    cnt_nxt           = cnt_r;
    sel_idx_nxt       = sel_idx_r;
    sel_act_nxt       = sel_act_r;
    idx_nxt           = idx_r;
    lim_nxt           = lim_r;
    first_nxt         = first_r;
    status_nxt        = status_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_status_nxt    = out_status_r;
    out_sel_idx_nxt   = out_sel_idx_r;
    out_sel_valid_nxt = out_sel_valid_r;
    out_total_nxt     = out_total_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_mode;
          held_nxt = in_left_held;
        end
      end
      S_DECODE: begin
        status_nxt = ST_OK;
        case (mode_r)
          MODE_CLEAR: begin
            cnt_nxt     = '0;
            sel_act_nxt = 1'b0;
            sel_idx_nxt = '0;
          end
          MODE_PRESS: begin
            sel_act_nxt = 1'b0;
            sel_idx_nxt = '0;
            idx_nxt     = '0;
            if (cnt_r == '0) begin
              sel_act_nxt = 1'b1;
              cnt_nxt     = CW'(1);
            end
          end
          MODE_DRAG: if (!sel_act_r) status_nxt = ST_NOSEL;
          MODE_RELEASE: begin
            sel_act_nxt = 1'b0;
            sel_idx_nxt = '0;
          end
          MODE_EVAL: begin
            if (cnt_r < CW'(2)) begin
              status_nxt = ST_FEW;
            end else begin
              idx_nxt   = '0;
              lim_nxt   = IW'(cnt_r - 1'b1);
              first_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_PRESS_CMP: begin
        if (sts.hit) begin
          sel_idx_nxt = idx_r;
          sel_act_nxt = 1'b1;
        end else if (press_last) begin
          if (list_full) begin
            status_nxt = ST_FULL;
          end else begin
            sel_idx_nxt = IW'(cnt_r);
            sel_act_nxt = 1'b1;
            cnt_nxt     = CW'(cnt_r + 1'b1);
          end
        end else begin
          idx_nxt = IW'(idx_r + 1'b1);
        end
      end
      S_EVAL_WR: begin
        if (round_end) begin
          idx_nxt   = '0;
          lim_nxt   = lim_m1;
          first_nxt = 1'b0;
        end else begin
          idx_nxt = IW'(idx_r + 1'b1);
        end
      end
      S_DONE: begin
        if (take) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = status_r;
          out_sel_idx_nxt   = 4'(sel_idx_r);
          out_sel_valid_nxt = sel_act_r;
          out_total_nxt     = 5'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      mode_r          <= MODE_CLEAR;
      held_r          <= 1'b0;
      cnt_r           <= CW'(1);
      sel_idx_r       <= '0;
      sel_act_r       <= 1'b0;
      idx_r           <= '0;
      lim_r           <= '0;
      first_r         <= 1'b0;
      status_r        <= ST_OK;
      out_valid_r     <= 1'b0;
      out_status_r    <= ST_OK;
      out_sel_idx_r   <= '0;
      out_sel_valid_r <= 1'b0;
      out_total_r     <= '0;
    end else begin
      state_r         <= state_nxt;
      mode_r          <= mode_nxt;
      held_r          <= held_nxt;
      cnt_r           <= cnt_nxt;
      sel_idx_r       <= sel_idx_nxt;
      sel_act_r       <= sel_act_nxt;
      idx_r           <= idx_nxt;
      lim_r           <= lim_nxt;
      first_r         <= first_nxt;
      status_r        <= status_nxt;
      out_valid_r     <= out_valid_nxt;
      out_status_r    <= out_status_nxt;
      out_sel_idx_r   <= out_sel_idx_nxt;
      out_sel_valid_r <= out_sel_valid_nxt;
      out_total_r     <= out_total_nxt;
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_selected_index = out_sel_idx_r;
  assign out_selected_valid = out_sel_valid_r;
  assign out_point_total    = out_total_r;

endmodule

// File: hdl/bre_dpath.sv
module bre_dpath #(
  parameter int MAX_POINTS = bre_pkg::MAX_POINTS_DEF,
  parameter int SLICES     = bre_pkg::SLICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_hit_radius,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [16:0]        in_curve_t,
  input  logic [5:0]         in_slice_index,
  input  bre_pkg::bre_cmd_t  cmd,
  output bre_pkg::bre_sts_t  sts,
  output logic signed [15:0] out_curve_x,
  output logic signed [15:0] out_curve_y,
  output logic signed [15:0] out_surface_x,
  output logic signed [15:0] out_surface_z
);
  import bre_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);

  logic [31:0] trig_tab [64];

  for (genvar g = 0; g < 64; g++) begin : g_trig
    localparam logic [31:0] TV = slice_trig(g, SLICES);
    assign trig_tab[g] = TV;
  end

  logic [31:0] pmem [MAX_POINTS];
  logic [31:0] wmem [MAX_POINTS];

  logic [14:0]        hit_radius_r;
  logic [29:0]        r2_r;
  logic               p0def_r;
  logic signed [15:0] pos_x_r, pos_y_r;
  logic [16:0]        t_r;
  logic [5:0]         slice_r;
  logic [31:0]        prd_r, wrd_r;
  logic               rd_src_r, rd_def_r;
  logic signed [15:0] prev_x_r, prev_y_r;
  logic signed [35:0] prod_x_r, prod_y_r;
  logic signed [15:0] cx_r, cy_r, sx_r, sz_r;
  logic signed [15:0] ox_r, oy_r, osx_r, osz_r;

  logic signed [15:0] rx, ry, sin_v, cos_v, new_x, new_y;
  logic signed [17:0] ax, bx, ay, by;
  logic signed [35:0] rnd_x, rnd_y;
  logic [33:0]        dist2;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] p);
    logic signed [35:0] v;
    v = (p + 36'sd8192) >>> 14;
    if (v > 36'sd32767)       return 16'sh7FFF;
    else if (v < -36'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  always_comb begin
    if (!rd_src_r)     rx = wrd_r[31:16];
    else if (rd_def_r) rx = POINT0_COORD;
    else               rx = prd_r[31:16];
    if (!rd_src_r)     ry = wrd_r[15:0];
    else if (rd_def_r) ry = POINT0_COORD;
    else               ry = prd_r[15:0];
  end

  assign sin_v = trig_tab[slice_r][31:16];
  assign cos_v = trig_tab[slice_r][15:0];

  always_comb begin
    case (cmd.mul_op)
      MUL_HIT: begin
        ax = 18'(rx) - 18'(pos_x_r);
        bx = ax;
        ay = 18'(ry) - 18'(pos_y_r);
        by = ay;
      end
      MUL_BLEND: begin
        ax = 18'(rx) - 18'(prev_x_r);
        bx = {1'b0, t_r};
        ay = 18'(ry) - 18'(prev_y_r);
        by = {1'b0, t_r};
      end
      MUL_REV: begin
        ax = 18'(cx_r);
        bx = 18'(cos_v);
        ay = 18'(cx_r);
        by = 18'(sin_v);
      end
      default: begin
        ax = '0;
        bx = '0;
        ay = '0;
        by = '0;
      end
    endcase
  end

  assign dist2   = {1'b0, prod_x_r[32:0]} + {1'b0, prod_y_r[32:0]};
  assign sts.hit = (dist2 < {4'b0, r2_r});

  assign rnd_x = (prod_x_r + 36'sd32768) >>> 16;
  assign rnd_y = (prod_y_r + 36'sd32768) >>> 16;
  assign new_x = prev_x_r + rnd_x[15:0];
  assign new_y = prev_y_r + rnd_y[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_radius_r <= HIT_RADIUS_RST;
      p0def_r      <= 1'b1;
    end else begin
      if (cfg_we) hit_radius_r <= cfg_hit_radius;
      if (cmd.pt_we && cmd.pt_addr == '0) p0def_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pt_we) pmem[cmd.pt_addr[IW-1:0]] <= {pos_x_r, pos_y_r};
    if (cmd.rd_en) prd_r <= pmem[cmd.rd_addr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.wk_we) wmem[cmd.wk_addr[IW-1:0]] <= {new_x, new_y};
    if (cmd.rd_en) wrd_r <= wmem[cmd.rd_addr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    r2_r     <= hit_radius_r * hit_radius_r;
    prod_x_r <= ax * bx;
    prod_y_r <= ay * by;
    if (cmd.latch_in) begin
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      t_r     <= (in_curve_t > T_ONE) ? T_ONE : in_curve_t;
      slice_r <= in_slice_index;
    end
    if (cmd.rd_en) begin
      rd_src_r <= cmd.src_point;
      rd_def_r <= (cmd.rd_addr == '0) && p0def_r;
    end
    if (cmd.ld_prev) begin
      prev_x_r <= rx;
      prev_y_r <= ry;
    end
    if (cmd.clr_result) begin
      cx_r <= '0;
      cy_r <= '0;
      sx_r <= '0;
      sz_r <= '0;
    end else begin
      if (cmd.ld_curve) begin
        cx_r <= new_x;
        cy_r <= new_y;
      end
      if (cmd.ld_surface) begin
        sx_r <= sat16(prod_x_r);
        sz_r <= sat16(prod_y_r);
      end
    end
    if (cmd.ld_out) begin
      ox_r  <= cx_r;
      oy_r  <= cy_r;
      osx_r <= sx_r;
      osz_r <= sz_r;
    end
  end

  assign out_curve_x   = ox_r;
  assign out_curve_y   = oy_r;
  assign out_surface_x = osx_r;
  assign out_surface_z = osz_r;

endmodule

// File: hdl/bezier_revolve_evaluator_unit.sv
// Editable Bezier control list with de Casteljau evaluation and revolve about y.
// One result transaction per input transaction. Clear, drag, release and
// unused modes go from decode straight to the done state and the output
// register. A press walks the stored points one at a time: read, square and
// compare for each point tested. An evaluate is bound by the single read port
// of the work memory and the shared pair of multipliers that also serve the
// hit test and the revolve. The input is taken again as soon as the result
// is in the output register. cfg_ready is always high; write hit_radius
// only while the block is idle.
module bezier_revolve_evaluator_unit #(
  parameter int MAX_POINTS = bre_pkg::MAX_POINTS_DEF,
  parameter int SLICES     = bre_pkg::SLICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_hit_radius,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic               in_left_held,
  input  logic [16:0]        in_curve_t,
  input  logic [5:0]         in_slice_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [3:0]         out_selected_index,
  output logic               out_selected_valid,
  output logic [4:0]         out_point_total,
  output logic signed [15:0] out_curve_x,
  output logic signed [15:0] out_curve_y,
  output logic signed [15:0] out_surface_x,
  output logic signed [15:0] out_surface_z
);
  import bre_pkg::*;

  bre_cmd_t cmd;
  bre_sts_t sts;

  assign cfg_ready = 1'b1;

  bre_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_left_held      (in_left_held),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_selected_index(out_selected_index),
    .out_selected_valid(out_selected_valid),
    .out_point_total   (out_point_total),
    .cmd               (cmd),
    .sts               (sts)
  );

  bre_dpath #(
    .MAX_POINTS(MAX_POINTS),
    .SLICES    (SLICES)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_hit_radius(cfg_hit_radius),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_curve_t    (in_curve_t),
    .in_slice_index(in_slice_index),
    .cmd           (cmd),
    .sts           (sts),
    .out_curve_x   (out_curve_x),
    .out_curve_y   (out_curve_y),
    .out_surface_x (out_surface_x),
    .out_surface_z (out_surface_z)
  );

endmodule
